// ===== src/tai_pkg.sv =====
// Shared types and constants of the tilt angle indicator
`timescale 1ns / 1ps
`default_nettype none
package tai_pkg;
	localparam int STEPS = 16;
	localparam logic signed [15:0] PI_Q12      = 16'sd12866;
	localparam logic signed [15:0] QUARTER_Q12 = 16'sd6434;
	localparam logic signed [19:0] PI_Q16      = 20'sd205887;
	localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [15:0] INV_GAIN_Q14 = 16'sd9949;

	localparam logic [1:0] KIND_ALPHA = 2'd0;
	localparam logic [1:0] KIND_BETA  = 2'd1;
	localparam logic [1:0] KIND_CHART = 2'd2;

	localparam logic [2:0] REG_ACX = 3'd0;
	localparam logic [2:0] REG_ACY = 3'd1;
	localparam logic [2:0] REG_AHL = 3'd2;
	localparam logic [2:0] REG_BCX = 3'd3;
	localparam logic [2:0] REG_BCY = 3'd4;
	localparam logic [2:0] REG_BHL = 3'd5;
	localparam logic [2:0] REG_TZR = 3'd6;
	localparam logic [2:0] REG_TAM = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE, ST_VEC_INIT, ST_VEC_RUN, ST_VEC_DONE,
		ST_ROT_INIT, ST_ROT_RUN, ST_ROT_DONE, ST_DOT_CALC, ST_DOT_OUT,
		ST_CHART_CALC, ST_CHART_OUT
	} state_t;

	typedef struct packed {
		logic       vec_init;
		logic       vec_step;
		logic       vec_done;
		logic       rot_init;
		logic       rot_step;
		logic       dot_calc;
		logic       chart_calc;
		logic       out_load;
		logic       sel_beta;
		logic [3:0] step;
		logic [3:0] dot;
		logic [1:0] kind;
		logic       axis;
		logic       col_adv;
	} ctl_t;

	function automatic logic signed [19:0] atan_tab(input logic [3:0] i);
		case (i)
			4'd0:  atan_tab = 20'sd51472;
			4'd1:  atan_tab = 20'sd30385;
			4'd2:  atan_tab = 20'sd16055;
			4'd3:  atan_tab = 20'sd8150;
			4'd4:  atan_tab = 20'sd4091;
			4'd5:  atan_tab = 20'sd2047;
			4'd6:  atan_tab = 20'sd1024;
			4'd7:  atan_tab = 20'sd512;
			4'd8:  atan_tab = 20'sd256;
			4'd9:  atan_tab = 20'sd128;
			4'd10: atan_tab = 20'sd64;
			4'd11: atan_tab = 20'sd32;
			4'd12: atan_tab = 20'sd16;
			4'd13: atan_tab = 20'sd8;
			4'd14: atan_tab = 20'sd4;
			default: atan_tab = 20'sd2;
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== src/tai_if.sv =====
// Handshake channel interfaces of the tilt angle indicator
`timescale 1ns / 1ps
`default_nettype none
interface tai_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	modport source (output valid, accel_x, accel_y, accel_z, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface tai_out_if;
	logic valid;
	logic ready;
	logic [1:0] item_kind;
	logic [3:0] dot_number;
	logic signed [9:0] pixel_x;
	logic signed [9:0] pixel_y;
	logic [7:0] chart_column;
	logic signed [9:0] chart_alpha_row;
	logic signed [9:0] chart_beta_row;
	logic rows_equal;
	logic signed [14:0] alpha_angle;
	logic signed [14:0] beta_angle;
	logic last_item;
	modport source (output valid, item_kind, dot_number, pixel_x, pixel_y, chart_column,
		chart_alpha_row, chart_beta_row, rows_equal, alpha_angle, beta_angle, last_item,
		input ready);
	modport sink (input valid, item_kind, dot_number, pixel_x, pixel_y, chart_column,
		chart_alpha_row, chart_beta_row, rows_equal, alpha_angle, beta_angle, last_item,
		output ready);
endinterface

interface tai_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [7:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/tai_ctrl.sv =====
// Sequencer of the tilt angle indicator
`timescale 1ns / 1ps
`default_nettype none
module tai_ctrl #(
	parameter int ALPHA_DOT_COUNT = 6,
	parameter int BETA_DOT_COUNT = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic out_busy,
	output tai_pkg::ctl_t ctl,
	output logic in_ready
);
	import tai_pkg::*;

	state_t state_q, state_d;
	logic [3:0] step_q, step_d;
	logic [3:0] dot_q, dot_d;
	logic axis_q, axis_d;
	logic beta_q, beta_d;
	logic [3:0] last_dot;

	assign last_dot = beta_q ? 4'(BETA_DOT_COUNT - 1) : 4'(ALPHA_DOT_COUNT - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			dot_q <= '0;
			axis_q <= 1'b0;
			beta_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			dot_q <= dot_d;
			axis_q <= axis_d;
			beta_q <= beta_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d = step_q;
		dot_d = dot_q;
		axis_d = axis_q;
		beta_d = beta_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_VEC_INIT;
					axis_d = 1'b0;
					beta_d = 1'b0;
				end
			end
			ST_VEC_INIT: begin
				state_d = ST_VEC_RUN;
				step_d = '0;
			end
			ST_VEC_RUN: begin
				step_d = step_q + 4'd1;
				if (step_q == 4'(STEPS - 1)) state_d = ST_VEC_DONE;
			end
			ST_VEC_DONE: begin
				if (axis_q) state_d = ST_ROT_INIT;
				else begin
					axis_d = 1'b1;
					state_d = ST_VEC_INIT;
				end
			end
			ST_ROT_INIT: begin
				state_d = ST_ROT_RUN;
				step_d = '0;
			end
			ST_ROT_RUN: begin
				step_d = step_q + 4'd1;
				if (step_q == 4'(STEPS - 1)) state_d = ST_ROT_DONE;
			end
			// lets the half-length product pick up the settled rotation
			ST_ROT_DONE: begin
				state_d = ST_DOT_CALC;
				dot_d = '0;
			end
			ST_DOT_CALC: begin
				if (!out_busy) state_d = ST_DOT_OUT;
			end
			ST_DOT_OUT: begin
				if (dot_q == last_dot) begin
					if (beta_q) state_d = ST_CHART_CALC;
					else begin
						beta_d = 1'b1;
						state_d = ST_ROT_INIT;
					end
				end else begin
					dot_d = dot_q + 4'd1;
					state_d = ST_DOT_CALC;
				end
			end
			ST_CHART_CALC: begin
				if (!out_busy) state_d = ST_CHART_OUT;
			end
			ST_CHART_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.step = step_q;
		ctl.dot = dot_q;
		ctl.axis = axis_q;
		ctl.sel_beta = beta_q;
		ctl.kind = beta_q ? KIND_BETA : KIND_ALPHA;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_VEC_INIT: ctl.vec_init = 1'b1;
			ST_VEC_RUN: ctl.vec_step = 1'b1;
			ST_VEC_DONE: ctl.vec_done = 1'b1;
			ST_ROT_INIT: ctl.rot_init = 1'b1;
			ST_ROT_RUN: ctl.rot_step = 1'b1;
			ST_DOT_CALC: ctl.dot_calc = 1'b1;
			ST_DOT_OUT: ctl.out_load = 1'b1;
			ST_CHART_CALC: begin
				ctl.chart_calc = 1'b1;
				ctl.kind = KIND_CHART;
			end
			ST_CHART_OUT: begin
				ctl.out_load = 1'b1;
				ctl.kind = KIND_CHART;
				ctl.col_adv = 1'b1;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/tai_dp.sv =====
// CORDIC, dot and chart datapath of the tilt angle indicator
`timescale 1ns / 1ps
`default_nettype none
module tai_dp #(
	parameter int ALPHA_DOT_COUNT = 6,
	parameter int BETA_DOT_COUNT = 12,
	parameter int CHART_LAST_COLUMN = 159
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  tai_pkg::ctl_t ctl,
	input  wire logic in_fire,
	input  wire logic signed [15:0] ax,
	input  wire logic signed [15:0] ay,
	input  wire logic signed [15:0] az,
	input  wire logic cfg_fire,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic out_ready,
	output logic out_valid,
	output logic [1:0] o_kind,
	output logic [3:0] o_dot,
	output logic signed [9:0] o_px,
	output logic signed [9:0] o_py,
	output logic [7:0] o_col,
	output logic signed [9:0] o_ra,
	output logic signed [9:0] o_rb,
	output logic o_eq,
	output logic signed [14:0] o_a,
	output logic signed [14:0] o_b,
	output logic o_last
);
	import tai_pkg::*;

	// reciprocals ceil(2^20/(n-1)) and ceil(2^34/pi_q12), exact for the operand ranges used
	localparam logic [20:0] A_RCP = 21'(((64'd1 << 20) + 64'(ALPHA_DOT_COUNT) - 64'd2) /
		64'(ALPHA_DOT_COUNT - 1));
	localparam logic [20:0] B_RCP = 21'(((64'd1 << 20) + 64'(BETA_DOT_COUNT) - 64'd2) /
		64'(BETA_DOT_COUNT - 1));
	localparam logic [20:0] PI_RCP = 21'(((64'd1 << 34) + 64'(PI_Q12) - 64'd1) / 64'(PI_Q12));

	logic [7:0] acx_q, bcx_q, col_q;
	logic [6:0] acy_q, ahl_q, bcy_q, bhl_q, tzr_q;
	logic [5:0] tam_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acx_q <= 8'd30; acy_q <= 7'd40; ahl_q <= 7'd14;
			bcx_q <= 8'd100; bcy_q <= 7'd40; bhl_q <= 7'd38;
			tzr_q <= 7'd90; tam_q <= 6'd28;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_ACX: acx_q <= cfg_data;
				REG_ACY: acy_q <= cfg_data[6:0];
				REG_AHL: ahl_q <= cfg_data[6:0];
				REG_BCX: bcx_q <= cfg_data;
				REG_BCY: bcy_q <= cfg_data[6:0];
				REG_BHL: bhl_q <= cfg_data[6:0];
				REG_TZR: tzr_q <= cfg_data[6:0];
				REG_TAM: tam_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) col_q <= '0;
		else if (ctl.col_adv) begin
			if ({1'b0, col_q} + 9'd1 > 9'(CHART_LAST_COLUMN)) col_q <= '0;
			else col_q <= col_q + 8'd1;
		end
	end

	// sample hold
	logic signed [15:0] sx_q, sy_q, sz_q;
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sx_q <= ax; sy_q <= ay; sz_q <= az;
		end
	end

	// shared CORDIC unit: x,y 34 bit signed, z 22 bit
	logic signed [33:0] cx_q, cy_q;
	logic signed [21:0] cz_q;
	logic signed [14:0] a_q, b_q;
	logic neg_q;
	logic signed [16:0] num, den, anum, aden;
	logic signed [33:0] xs, ys;
	logic signed [21:0] tab;
	logic signed [21:0] zc;
	logic signed [15:0] base, qv;
	logic signed [21:0] z16, zr;

	assign num = ctl.axis ? 17'(sy_q) : 17'(sx_q);
	assign den = 17'(sz_q);
	assign anum = num < 0 ? -num : num;
	assign aden = den < 0 ? -den : den;
	assign xs = cx_q >>> ctl.step;
	assign ys = cy_q >>> ctl.step;
	assign tab = 22'(atan_tab(ctl.step));

	always_comb begin
		zc = cz_q;
		if (zc < 0) zc = '0;
		if (zc > 22'(HALF_PI_Q16)) zc = 22'(HALF_PI_Q16);
		base = (num == 0) ? 16'sd0 : 16'((zc + 22'sd8) >>> 4);
		qv = ((num < 0) != (den < 0)) ? -base : base;
		if (den < 0) qv = qv + ((num < 0) ? -PI_Q12 : PI_Q12);
		if (den == 0) qv = (num > 0) ? QUARTER_Q12 : ((num < 0) ? -QUARTER_Q12 : 16'sd0);
	end

	assign z16 = 22'(ctl.sel_beta ? b_q : a_q) * 22'sd16;
	always_comb begin
		zr = z16;
		if (z16 > 22'(HALF_PI_Q16)) zr = z16 - 22'(PI_Q16);
		else if (z16 < -22'(HALF_PI_Q16)) zr = z16 + 22'(PI_Q16);
	end

	always_ff @(posedge clk) begin
		if (ctl.vec_init) begin
			cx_q <= 34'(aden) <<< 14;
			cy_q <= 34'(anum) <<< 14;
			cz_q <= '0;
		end else if (ctl.vec_step) begin
			if (cy_q >= 0) begin
				cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + tab;
			end else begin
				cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - tab;
			end
		end else if (ctl.rot_init) begin
			cx_q <= 34'(INV_GAIN_Q14);
			cy_q <= '0;
			cz_q <= zr;
		end else if (ctl.rot_step) begin
			if (cz_q >= 0) begin
				cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - tab;
			end else begin
				cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + tab;
			end
		end
		if (ctl.vec_done) begin
			if (ctl.axis) b_q <= 15'(qv);
			else a_q <= 15'(qv);
		end
		if (ctl.rot_init) neg_q <= (z16 > 22'(HALF_PI_Q16)) || (z16 < -22'(HALF_PI_Q16));
	end

	// dot arithmetic: hl*trig product registered, then k times, then rounding
	logic signed [18:0] trc, trs;
	logic signed [7:0] hl;
	logic signed [27:0] pc_q, ps_q;
	logic signed [5:0] kk;
	logic [4:0] nn;
	logic signed [19:0] dn;
	logic signed [33:0] tx, ty;
	logic signed [9:0] px_d, py_d;
	logic signed [8:0] ccx, ccy;

	assign trc = neg_q ? -19'(cx_q) : 19'(cx_q);
	assign trs = neg_q ? -19'(cy_q) : 19'(cy_q);
	assign hl = 8'({1'b0, ctl.sel_beta ? bhl_q : ahl_q});
	assign nn = ctl.sel_beta ? 5'(BETA_DOT_COUNT) : 5'(ALPHA_DOT_COUNT);
	assign kk = 6'({2'b0, ctl.dot} <<< 1) - 6'(nn) + 6'sd1;
	assign dn = 20'(nn - 5'd1) <<< 14;
	assign ccx = 9'({1'b0, ctl.sel_beta ? bcx_q : acx_q});
	assign ccy = 9'({2'b0, ctl.sel_beta ? bcy_q : acy_q});

	// follows the rotation every cycle; settled once it has registered the rotation's final result
	always_ff @(posedge clk) begin
		pc_q <= 28'(hl) * 28'(trc);
		ps_q <= 28'(hl) * 28'(trs);
	end

	// the denominator (n-1)*2^14 with n fixed per line: divide by n-1 through a
	// reciprocal multiplication
	function automatic logic signed [9:0] rnd(input logic signed [33:0] t,
		input logic [4:0] nm1, input logic [20:0] rcp);
		logic [34:0] m;
		logic [36:0] q;
		begin
			m = t < 0 ? 35'(-t) : 35'(t);
			m = (m + (35'(nm1) << 13)) >> 14;
			// m now is floor((|t|+d/2)/2^14) refined below
			q = (37'(m[15:0]) * 37'(rcp)) >> 20;
			rnd = t < 0 ? -10'(q) : 10'(q);
		end
	endfunction
	logic signed [33:0] tx_s1, ty_s1;
	logic [4:0] nm1_s1;
	logic [20:0] rcp_s1;
	always_ff @(posedge clk) begin
		if (ctl.dot_calc) begin
			tx_s1 <= 34'(ccx) * 34'(dn) + 34'(pc_q) * 34'(kk);
			ty_s1 <= 34'(ccy) * 34'(dn) + 34'(ps_q) * 34'(kk);
			nm1_s1 <= nn - 5'd1;
			rcp_s1 <= ctl.sel_beta ? B_RCP : A_RCP;
		end
	end
	assign tx = tx_s1;
	assign ty = ty_s1;
	// floor((|t|+d/2)/d) = floor(floor((|t|+d/2)/2^14)/(n-1)) holds since d = (n-1)*2^14
	assign px_d = rnd(tx, nm1_s1, rcp_s1);
	assign py_d = rnd(ty, nm1_s1, rcp_s1);

	// chart rows
	logic signed [21:0] pa_q, pb_q;
	logic signed [9:0] ra, rb;
	function automatic logic signed [9:0] crow(input logic signed [21:0] p,
		input logic [6:0] zr0);
		logic [21:0] m;
		logic [42:0] q;
		begin
			m = p < 0 ? 22'(-p) : 22'(p);
			q = (43'(m) * 43'(PI_RCP)) >> 34;
			crow = 10'({3'b0, zr0}) - (p < 0 ? -10'(q) : 10'(q));
		end
	endfunction
	always_ff @(posedge clk) begin
		if (ctl.chart_calc) begin
			pa_q <= 22'(a_q) * 22'($signed({1'b0, tam_q}));
			pb_q <= 22'(b_q) * 22'($signed({1'b0, tam_q}));
		end
	end
	assign ra = crow(pa_q, tzr_q);
	assign rb = crow(pb_q, tzr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (ctl.out_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			o_kind <= ctl.kind;
			o_a <= a_q;
			o_b <= b_q;
			if (ctl.kind == KIND_CHART) begin
				o_dot <= '0; o_px <= '0; o_py <= '0;
				o_col <= col_q; o_ra <= ra; o_rb <= rb; o_eq <= (ra == rb);
				o_last <= 1'b1;
			end else begin
				o_dot <= ctl.dot; o_px <= px_d; o_py <= py_d;
				o_col <= '0; o_ra <= '0; o_rb <= '0; o_eq <= 1'b0;
				o_last <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/tilt_angle_indicator_top.sv =====
// Top level of the tilt angle indicator
// channel  dir  payload
// in       in   accel_x, accel_y, accel_z
// cfg      in   index, data
// out      out  dot and chart result items
// Each sample runs the shared CORDIC unit as arctangent CORDIC for both axes, then
// as sine/cosine CORDIC for each line, with a calculate and an output state per
// emitted item. arst_n clears control, registers to their defaults and the column.
// A stalled output holds the sequencer; no new sample is taken until the chart item.
`timescale 1ns / 1ps
`default_nettype none
module tilt_angle_indicator_top #(
	parameter int ALPHA_DOT_COUNT = 6,
	parameter int BETA_DOT_COUNT = 12,
	parameter int CHART_LAST_COLUMN = 159
) (
	input wire logic clk,
	input wire logic arst_n,
	tai_in_if.sink in_ch,
	tai_cfg_if.sink cfg,
	tai_out_if.source out_ch
);
	import tai_pkg::*;

	ctl_t ctl;
	logic in_fire, in_ready;

	assign in_ch.ready = in_ready;
	assign in_fire = in_ch.valid && in_ready;
	assign cfg.ready = 1'b1;

	tai_ctrl #(.ALPHA_DOT_COUNT(ALPHA_DOT_COUNT), .BETA_DOT_COUNT(BETA_DOT_COUNT)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_busy(out_ch.valid && !out_ch.ready), .ctl(ctl), .in_ready(in_ready)
	);

	tai_dp #(.ALPHA_DOT_COUNT(ALPHA_DOT_COUNT), .BETA_DOT_COUNT(BETA_DOT_COUNT),
		.CHART_LAST_COLUMN(CHART_LAST_COLUMN)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .in_fire(in_fire),
		.ax(in_ch.accel_x), .ay(in_ch.accel_y), .az(in_ch.accel_z),
		.cfg_fire(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.out_ready(out_ch.ready), .out_valid(out_ch.valid),
		.o_kind(out_ch.item_kind), .o_dot(out_ch.dot_number),
		.o_px(out_ch.pixel_x), .o_py(out_ch.pixel_y), .o_col(out_ch.chart_column),
		.o_ra(out_ch.chart_alpha_row), .o_rb(out_ch.chart_beta_row),
		.o_eq(out_ch.rows_equal), .o_a(out_ch.alpha_angle), .o_b(out_ch.beta_angle),
		.o_last(out_ch.last_item)
	);
endmodule
`default_nettype wire

// ===== bench/tai_checker.sv =====
// Checker for the tilt angle indicator: predicts result items and compares them
`timescale 1ns / 1ps
`default_nettype none
module tai_checker import tai_pkg::*; #(
	parameter int ALPHA_DOT_COUNT = 6,
	parameter int BETA_DOT_COUNT = 12,
	parameter int CHART_LAST_COLUMN = 159
) (
	input wire logic clk,
	input wire logic arst_n,
	tai_in_if.source in_ch,
	tai_cfg_if.source cfg,
	tai_out_if.sink out_ch,
	output int errors,
	output int pending
);
	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] dot;
		logic signed [9:0] px;
		logic signed [9:0] py;
		logic [7:0] col;
		logic signed [9:0] ra;
		logic signed [9:0] rb;
		logic eq;
		logic signed [14:0] a;
		logic signed [14:0] b;
		logic last;
	} tilt_item_t;

	tilt_item_t expected_items[$];
	logic [7:0] acx, bcx, column;
	logic [6:0] acy, ahl, bcy, bhl, zero_row;
	logic [5:0] amp;

	function automatic longint shr_floor(longint v, int s);
		if (v >= 0) return v >>> s;
		return -(((-v) - 1) >>> s) - 1;
	endfunction

	function automatic longint atan_q16(int i);
		longint t[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		return t[i];
	endfunction

	function automatic longint tilt_angle(longint n, longint d);
		longint x, y, z, xs, ys, base, q;
		base = 0;
		if (d == 0) return n > 0 ? 6434 : (n < 0 ? -6434 : 0);
		if (n != 0) begin
			x = (d < 0 ? -d : d) * 16384;
			y = (n < 0 ? -n : n) * 16384;
			z = 0;
			for (int i = 0; i < 16; i++) begin
				xs = shr_floor(x, i);
				ys = shr_floor(y, i);
				if (y >= 0) begin
					x += ys; y -= xs; z += atan_q16(i);
				end else begin
					x -= ys; y += xs; z -= atan_q16(i);
				end
			end
			if (z < 0) z = 0;
			if (z > 102944) z = 102944;
			base = (z + 8) >>> 4;
		end
		q = ((n < 0) != (d < 0)) ? -base : base;
		if (d < 0) q += (n < 0) ? -12866 : 12866;
		return q;
	endfunction

	function automatic longint round_away(longint t, longint d);
		if (t >= 0) return (2 * t + d) / (2 * d);
		return -((-2 * t + d) / (2 * d));
	endfunction

	function automatic longint chart_row_of(longint ang);
		longint p, m;
		p = longint'(amp) * ang;
		m = (p < 0 ? -p : p) / 12866;
		return longint'(zero_row) - (p < 0 ? -m : m);
	endfunction

	task automatic push_line(logic [1:0] kind, int n, longint cx, longint cy, longint hl,
			longint ang, longint a, longint b);
		longint z, x, y, xs, ys, den, k;
		bit neg;
		tilt_item_t it;
		z = ang * 16; x = 9949; y = 0; neg = 0;
		if (z > 102944) begin
			z -= 205887; neg = 1;
		end else if (z < -102944) begin
			z += 205887; neg = 1;
		end
		for (int i = 0; i < 16; i++) begin
			xs = shr_floor(x, i);
			ys = shr_floor(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_q16(i);
			end else begin
				x += ys; y -= xs; z += atan_q16(i);
			end
		end
		if (neg) begin
			x = -x; y = -y;
		end
		den = longint'(n - 1) * 16384;
		for (int j = 0; j < n; j++) begin
			k = 2 * j - n + 1;
			it = '0;
			it.kind = kind;
			it.dot = j;
			it.px = round_away(cx * den + hl * x * k, den);
			it.py = round_away(cy * den + hl * y * k, den);
			it.a = a;
			it.b = b;
			expected_items.push_back(it);
		end
	endtask

	task automatic predict_sample(logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az);
		longint a, b, ra, rb;
		tilt_item_t it;
		a = tilt_angle(ax, az);
		b = tilt_angle(ay, az);
		push_line(KIND_ALPHA, ALPHA_DOT_COUNT, acx, acy, ahl, a, a, b);
		push_line(KIND_BETA, BETA_DOT_COUNT, bcx, bcy, bhl, b, a, b);
		ra = chart_row_of(a);
		rb = chart_row_of(b);
		it = '0;
		it.kind = KIND_CHART;
		it.col = column;
		it.ra = ra;
		it.rb = rb;
		it.eq = (ra == rb);
		it.a = a;
		it.b = b;
		it.last = 1;
		expected_items.push_back(it);
		column = (int'(column) + 1 > CHART_LAST_COLUMN) ? 8'd0 : column + 8'd1;
	endtask

	assign pending = expected_items.size();

	always @(posedge clk or negedge arst_n) begin
		tilt_item_t got, want;
		if (!arst_n) begin
			acx <= 30; acy <= 40; ahl <= 14; bcx <= 100; bcy <= 40; bhl <= 38;
			zero_row <= 90; amp <= 28; column <= 0;
			errors <= 0;
			expected_items.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_ACX: acx <= cfg.data;
					REG_ACY: acy <= cfg.data[6:0];
					REG_AHL: ahl <= cfg.data[6:0];
					REG_BCX: bcx <= cfg.data;
					REG_BCY: bcy <= cfg.data[6:0];
					REG_BHL: bhl <= cfg.data[6:0];
					REG_TZR: zero_row <= cfg.data[6:0];
					default: amp <= cfg.data[5:0];
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				predict_sample(in_ch.accel_x, in_ch.accel_y, in_ch.accel_z);
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.item_kind, out_ch.dot_number, out_ch.pixel_x, out_ch.pixel_y,
					out_ch.chart_column, out_ch.chart_alpha_row, out_ch.chart_beta_row,
					out_ch.rows_equal, out_ch.alpha_angle, out_ch.beta_angle,
					out_ch.last_item};
				if (expected_items.size() == 0) begin
					$display("%t unexpected item: got %p", $realtime, got);
					errors <= errors + 1;
				end else begin
					want = expected_items.pop_front();
					if (got !== want) begin
						$display("%t item differs: expected %p actual %p", $realtime, want, got);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== bench/tilt_angle_indicator_top_tb.sv =====
// Testbench top: stimulus, configuration phases and verdict for the tilt angle indicator
`timescale 1ns / 1ps
`default_nettype none
module tilt_angle_indicator_top_tb;
	import tai_pkg::*;
	logic clk, arst_n;
	int errors, pending, sent;
	bit idle_free, hold_long;

	tai_in_if in_ch();
	tai_cfg_if cfg();
	tai_out_if out_ch();

	tilt_angle_indicator_top dut(.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .cfg(cfg.sink),
		.out_ch(out_ch.source));
	tai_checker chk(.clk(clk), .arst_n(arst_n), .in_ch(in_ch.source), .cfg(cfg.source),
		.out_ch(out_ch.sink), .errors(errors), .pending(pending));

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tilt_angle_indicator_top: mismatch");
		$finish;
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int n;
		out_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				out_ch.ready = 0;
				repeat (400) @(negedge clk);
				hold_long = 0;
			end
			if (!idle_free && $urandom_range(0, 5) == 0) begin
				out_ch.ready = 0;
				n = $urandom_range(1, 8);
				repeat (n - 1) @(negedge clk);
			end else
				out_ch.ready = 1;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [7:0] val);
		cfg.index = idx;
		cfg.data = val;
		cfg.valid = 1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid = 0;
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic send(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
		if (!idle_free && $urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 8)) @(negedge clk);
		in_ch.accel_x = x;
		in_ch.accel_y = y;
		in_ch.accel_z = z;
		in_ch.valid = 1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		in_ch.valid = 0;
		sent++;
	endtask

	function automatic logic signed [15:0] pick();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return $urandom_range(0, 40) - 20;
			2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_config(bit extreme);
		for (int r = 0; r < 8; r++)
			if (extreme)
				write_reg(r, $urandom_range(0, 1) ? 8'hff : 8'h00);
			else
				write_reg(r, (r == REG_ACX || r == REG_BCX) ? $urandom_range(0, 159) :
					$urandom_range(0, 127));
	endtask

	initial begin
		int guard;
		arst_n = 0;
		in_ch.valid = 0; in_ch.accel_x = 0; in_ch.accel_y = 0; in_ch.accel_z = 0;
		cfg.valid = 0; cfg.index = REG_ACX; cfg.data = 0;
		sent = 0; idle_free = 0; hold_long = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: zeros, axis extremes, quadrants, vertical and level cases
		send(0, 0, 0);
		send(0, 0, 16'sh7fff);
		send(0, 0, 16'sh8000);
		send(16'sh7fff, 16'sh8000, 0);
		send(16'sh8000, 16'sh7fff, 0);
		send(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send(16'sh8000, 16'sh8000, 16'sh8000);
		send(16'sh7fff, 16'sh8000, 16'sh8000);
		send(16'sh8000, 16'sh7fff, 16'sh7fff);
		send(1, -1, -1);
		send(-1, 1, 1);
		send(16'shffff, 16'sh5555, 16'shaaaa);
		send(100, -100, 0);
		drain();
		write_reg(REG_ACX, 159); write_reg(REG_ACY, 127); write_reg(REG_AHL, 127);
		write_reg(REG_BCX, 0); write_reg(REG_BCY, 0); write_reg(REG_BHL, 127);
		write_reg(REG_TZR, 127); write_reg(REG_TAM, 63);
		send(16'sh8000, 16'sh7fff, -1);
		send(16'sh7fff, 16'sh8000, 16'sh8000);
		send(0, 0, 0);
		drain();
		random_config(1);
		send(16'sh8000, 16'sh7fff, 16'sh8000);
		send(16'sh7fff, 16'sh8000, 1);
		drain();
		// long receiver hold-off while samples keep coming
		hold_long = 1;
		for (int p = 0; p < 4; p++) send(pick(), pick(), pick());
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			random_config(ph == 2);
			for (int i = 0; i < 50; i++) send(pick(), pick(), pick());
		end
		drain();
		idle_free = 1;
		for (int i = 0; i < 20; i++) send(pick(), pick(), pick());
		guard = 0;
		while (pending != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (120) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("tilt_angle_indicator_top: match");
		else
			$display("tilt_angle_indicator_top: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
